[sv/isld_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isld_pkg
// Shared types, constants and the opcode decode table for the instruction
// stream length decoder.
// ----------------------------------------------------------------------------
package isld_pkg;

  localparam int PAGE_BYTES = 256;
  localparam int PAGE_BITS  = $clog2(PAGE_BYTES);

  localparam logic [7:0] OP_BRK = 8'h00;
  localparam logic [5:0] MN_BRK = 6'd10;

  typedef enum logic [3:0] {
    AM_ACC  = 4'd0,
    AM_ABS  = 4'd1,
    AM_ABSX = 4'd2,
    AM_ABSY = 4'd3,
    AM_IMM  = 4'd4,
    AM_IMPL = 4'd5,
    AM_IND  = 4'd6,
    AM_INDX = 4'd7,
    AM_INDY = 4'd8,
    AM_REL  = 4'd9,
    AM_ZPG  = 4'd10,
    AM_ZPGX = 4'd11,
    AM_ZPGY = 4'd12
  } addr_mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNDEF    = 2'd1,
    ST_PAST_TOP = 2'd2,
    ST_BRK_END  = 2'd3
  } status_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] mn;
    addr_mode_t mode;
  } op_info_t;

  typedef struct packed {
    logic [15:0] instr_addr;
    logic [7:0]  opcode;
    logic [5:0]  mnemonic_code;
    addr_mode_t  addr_mode;
    logic [15:0] operand;
    logic [1:0]  instr_len;
    status_t     status;
  } isld_rec_t;

  typedef struct packed {
    logic      valid;
    isld_rec_t rec;
  } isld_push_t;

  function automatic logic [1:0] mode_len(input addr_mode_t m);
    logic [1:0] l;
    case (m)
      AM_ACC, AM_IMPL:                       l = 2'd1;
      AM_ABS, AM_ABSX, AM_ABSY, AM_IND:      l = 2'd3;
      default:                               l = 2'd2;
    endcase
    return l;
  endfunction

  function automatic op_info_t mk(input logic [5:0] mn, input addr_mode_t m);
    op_info_t e;
    e.valid = 1'b1;
    e.mn    = mn;
    e.mode  = m;
    return e;
  endfunction

  function automatic op_info_t op_lookup(input logic [7:0] op);
    op_info_t e;
    case (op)
      8'h00: e = mk(6'd10, AM_IMPL);  8'h01: e = mk(6'd34, AM_INDX);
      8'h05: e = mk(6'd34, AM_ZPG);   8'h06: e = mk(6'd2,  AM_ZPG);
      8'h08: e = mk(6'd36, AM_IMPL);  8'h09: e = mk(6'd34, AM_IMM);
      8'h0A: e = mk(6'd2,  AM_ACC);   8'h0D: e = mk(6'd34, AM_ABS);
      8'h0E: e = mk(6'd2,  AM_ABS);
      8'h10: e = mk(6'd9,  AM_REL);   8'h11: e = mk(6'd34, AM_INDY);
      8'h15: e = mk(6'd34, AM_ZPGX);  8'h16: e = mk(6'd2,  AM_ZPGX);
      8'h18: e = mk(6'd13, AM_IMPL);  8'h19: e = mk(6'd34, AM_ABSY);
      8'h1D: e = mk(6'd34, AM_ABSX);  8'h1E: e = mk(6'd2,  AM_ABSX);
      8'h20: e = mk(6'd28, AM_ABS);   8'h21: e = mk(6'd1,  AM_INDX);
      8'h24: e = mk(6'd6,  AM_ZPG);   8'h25: e = mk(6'd1,  AM_ZPG);
      8'h26: e = mk(6'd39, AM_ZPG);   8'h28: e = mk(6'd38, AM_IMPL);
      8'h29: e = mk(6'd1,  AM_IMM);   8'h2A: e = mk(6'd39, AM_ACC);
      8'h2C: e = mk(6'd6,  AM_ABS);   8'h2D: e = mk(6'd1,  AM_ABS);
      8'h2E: e = mk(6'd39, AM_ABS);
      8'h30: e = mk(6'd7,  AM_REL);   8'h31: e = mk(6'd1,  AM_INDY);
      8'h35: e = mk(6'd1,  AM_ZPGX);  8'h36: e = mk(6'd39, AM_ZPGX);
      8'h38: e = mk(6'd44, AM_IMPL);  8'h39: e = mk(6'd1,  AM_ABSY);
      8'h3D: e = mk(6'd1,  AM_ABSX);  8'h3E: e = mk(6'd39, AM_ABSX);
      8'h40: e = mk(6'd41, AM_IMPL);  8'h41: e = mk(6'd23, AM_INDX);
      8'h45: e = mk(6'd23, AM_ZPG);   8'h46: e = mk(6'd32, AM_ZPG);
      8'h48: e = mk(6'd35, AM_IMPL);  8'h49: e = mk(6'd23, AM_IMM);
      8'h4A: e = mk(6'd32, AM_ACC);   8'h4C: e = mk(6'd27, AM_ABS);
      8'h4D: e = mk(6'd23, AM_ABS);   8'h4E: e = mk(6'd32, AM_ABS);
      8'h50: e = mk(6'd11, AM_REL);   8'h51: e = mk(6'd23, AM_INDY);
      8'h55: e = mk(6'd23, AM_ZPGX);  8'h56: e = mk(6'd32, AM_ZPGX);
      8'h58: e = mk(6'd15, AM_IMPL);  8'h59: e = mk(6'd23, AM_ABSY);
      8'h5D: e = mk(6'd23, AM_ABSX);  8'h5E: e = mk(6'd32, AM_ABSX);
      8'h60: e = mk(6'd42, AM_IMPL);  8'h61: e = mk(6'd0,  AM_INDX);
      8'h65: e = mk(6'd0,  AM_ZPG);   8'h66: e = mk(6'd40, AM_ZPG);
      8'h68: e = mk(6'd37, AM_IMPL);  8'h69: e = mk(6'd0,  AM_IMM);
      8'h6A: e = mk(6'd40, AM_ACC);   8'h6C: e = mk(6'd27, AM_IND);
      8'h6D: e = mk(6'd0,  AM_ABS);   8'h6E: e = mk(6'd40, AM_ABS);
      8'h70: e = mk(6'd12, AM_REL);   8'h71: e = mk(6'd0,  AM_INDY);
      8'h75: e = mk(6'd0,  AM_ZPGX);  8'h76: e = mk(6'd40, AM_ZPGX);
      8'h78: e = mk(6'd46, AM_IMPL);  8'h79: e = mk(6'd0,  AM_ABSY);
      8'h7D: e = mk(6'd0,  AM_ABSX);  8'h7E: e = mk(6'd40, AM_ABSX);
      8'h81: e = mk(6'd47, AM_INDX);  8'h84: e = mk(6'd49, AM_ZPG);
      8'h85: e = mk(6'd47, AM_ZPG);   8'h86: e = mk(6'd48, AM_ZPG);
      8'h88: e = mk(6'd22, AM_IMPL);  8'h8A: e = mk(6'd53, AM_IMPL);
      8'h8C: e = mk(6'd49, AM_ABS);   8'h8D: e = mk(6'd47, AM_ABS);
      8'h8E: e = mk(6'd48, AM_ABS);
      8'h90: e = mk(6'd3,  AM_REL);   8'h91: e = mk(6'd47, AM_INDY);
      8'h94: e = mk(6'd49, AM_ZPGX);  8'h95: e = mk(6'd47, AM_ZPGX);
      8'h96: e = mk(6'd48, AM_ZPGY);  8'h98: e = mk(6'd55, AM_IMPL);
      8'h99: e = mk(6'd47, AM_ABSY);  8'h9A: e = mk(6'd54, AM_IMPL);
      8'h9D: e = mk(6'd47, AM_ABSX);
      8'hA0: e = mk(6'd31, AM_IMM);   8'hA1: e = mk(6'd29, AM_INDX);
      8'hA2: e = mk(6'd30, AM_IMM);   8'hA4: e = mk(6'd31, AM_ZPG);
      8'hA5: e = mk(6'd29, AM_ZPG);   8'hA6: e = mk(6'd30, AM_ZPG);
      8'hA8: e = mk(6'd51, AM_IMPL);  8'hA9: e = mk(6'd29, AM_IMM);
      8'hAA: e = mk(6'd50, AM_IMPL);  8'hAC: e = mk(6'd31, AM_ABS);
      8'hAD: e = mk(6'd29, AM_ABS);   8'hAE: e = mk(6'd30, AM_ABS);
      8'hB0: e = mk(6'd4,  AM_REL);   8'hB1: e = mk(6'd29, AM_INDY);
      8'hB4: e = mk(6'd31, AM_ZPGX);  8'hB5: e = mk(6'd29, AM_ZPGX);
      8'hB6: e = mk(6'd30, AM_ZPGY);  8'hB8: e = mk(6'd16, AM_IMPL);
      8'hB9: e = mk(6'd29, AM_ABSY);  8'hBA: e = mk(6'd52, AM_IMPL);
      8'hBC: e = mk(6'd31, AM_ABSX);  8'hBD: e = mk(6'd29, AM_ABSX);
      8'hBE: e = mk(6'd30, AM_ABSY);
      8'hC0: e = mk(6'd19, AM_IMM);   8'hC1: e = mk(6'd17, AM_INDX);
      8'hC4: e = mk(6'd19, AM_ZPG);   8'hC5: e = mk(6'd17, AM_ZPG);
      8'hC6: e = mk(6'd20, AM_ZPG);   8'hC8: e = mk(6'd26, AM_IMPL);
      8'hC9: e = mk(6'd17, AM_IMM);   8'hCA: e = mk(6'd21, AM_IMPL);
      8'hCC: e = mk(6'd19, AM_ABS);   8'hCD: e = mk(6'd17, AM_ABS);
      8'hCE: e = mk(6'd20, AM_ABS);
      8'hD0: e = mk(6'd8,  AM_REL);   8'hD1: e = mk(6'd17, AM_INDY);
      8'hD5: e = mk(6'd17, AM_ZPGX);  8'hD6: e = mk(6'd20, AM_ZPGX);
      8'hD8: e = mk(6'd14, AM_IMPL);  8'hD9: e = mk(6'd17, AM_ABSY);
      8'hDD: e = mk(6'd17, AM_ABSX);  8'hDE: e = mk(6'd20, AM_ABSX);
      8'hE0: e = mk(6'd18, AM_IMM);   8'hE1: e = mk(6'd43, AM_INDX);
      8'hE4: e = mk(6'd18, AM_ZPG);   8'hE5: e = mk(6'd43, AM_ZPG);
      8'hE6: e = mk(6'd24, AM_ZPG);   8'hE8: e = mk(6'd25, AM_IMPL);
      8'hE9: e = mk(6'd43, AM_IMM);   8'hEA: e = mk(6'd33, AM_IMPL);
      8'hEC: e = mk(6'd18, AM_ABS);   8'hED: e = mk(6'd43, AM_ABS);
      8'hEE: e = mk(6'd24, AM_ABS);
      8'hF0: e = mk(6'd5,  AM_REL);   8'hF1: e = mk(6'd43, AM_INDY);
      8'hF5: e = mk(6'd43, AM_ZPGX);  8'hF6: e = mk(6'd24, AM_ZPGX);
      8'hF8: e = mk(6'd45, AM_IMPL);  8'hF9: e = mk(6'd43, AM_ABSY);
      8'hFD: e = mk(6'd43, AM_ABSX);  8'hFE: e = mk(6'd24, AM_ABSX);
      default: begin
        e.valid = 1'b0;
        e.mn    = 6'd0;
        e.mode  = AM_ACC;
      end
    endcase
    return e;
  endfunction

endpackage

[sv/isld_walker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isld_walker
// Tracks instruction boundaries, decodes opcodes, gathers operand bytes and
// forms one record per finished instruction or stop.
// ----------------------------------------------------------------------------
module isld_walker import isld_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  logic [7:0]  data_byte,
  input  logic [15:0] byte_addr,
  input  logic        restart,
  input  logic [15:0] memory_top,
  output isld_push_t  push
);

  logic        halted, halted_next;
  logic [1:0]  bytes_left, bytes_left_next;
  logic [15:0] cur_addr, cur_addr_next;
  logic [7:0]  cur_opcode, cur_opcode_next;
  logic [5:0]  cur_mn, cur_mn_next;
  addr_mode_t  cur_mode, cur_mode_next;
  logic [7:0]  operand_low, operand_low_next;

  op_info_t    info;
  logic [1:0]  len;
  logic [1:0]  cur_len;
  logic [1:0]  bl_eff;
  logic        running;

  assign info    = op_lookup(data_byte);
  assign len     = mode_len(info.mode);
  assign cur_len = mode_len(cur_mode);
  assign running = restart | ~halted;
  assign bl_eff  = restart ? 2'd0 : bytes_left;

  always_comb begin
    halted_next      = halted;
    bytes_left_next  = bytes_left;
    cur_addr_next    = cur_addr;
    cur_opcode_next  = cur_opcode;
    cur_mn_next      = cur_mn;
    cur_mode_next    = cur_mode;
    operand_low_next = operand_low;
    push.valid       = 1'b0;
    push.rec         = '{instr_addr: byte_addr, opcode: data_byte,
                         mnemonic_code: info.mn, addr_mode: info.mode,
                         operand: 16'd0, instr_len: 2'd0, status: ST_OK};
    if (fire && running) begin
      halted_next     = 1'b0;
      bytes_left_next = bl_eff;
      if (bl_eff == 2'd0) begin
        if (!info.valid) begin
          push.valid                 = 1'b1;
          push.rec.mnemonic_code     = 6'd0;
          push.rec.addr_mode         = AM_ACC;
          push.rec.status            = ST_UNDEF;
          halted_next                = 1'b1;
        end else if (data_byte == OP_BRK && (&byte_addr[PAGE_BITS-1:0])) begin
          push.valid                 = 1'b1;
          push.rec.mnemonic_code     = MN_BRK;
          push.rec.addr_mode         = AM_IMPL;
          push.rec.status            = ST_BRK_END;
          halted_next                = 1'b1;
        end else if (byte_addr > memory_top) begin
          push.valid                 = 1'b1;
          push.rec.status            = ST_PAST_TOP;
          halted_next                = 1'b1;
        end else if (len == 2'd1) begin
          push.valid                 = 1'b1;
          push.rec.instr_len         = 2'd1;
        end else begin
          cur_addr_next    = byte_addr;
          cur_opcode_next  = data_byte;
          cur_mn_next      = info.mn;
          cur_mode_next    = info.mode;
          operand_low_next = 8'd0;
          bytes_left_next  = len - 2'd1;
        end
      end else if (bl_eff == 2'd2) begin
        operand_low_next = data_byte;
        bytes_left_next  = 2'd1;
      end else begin
        bytes_left_next        = 2'd0;
        push.valid             = 1'b1;
        push.rec.instr_addr    = cur_addr;
        push.rec.opcode        = cur_opcode;
        push.rec.mnemonic_code = cur_mn;
        push.rec.addr_mode     = cur_mode;
        push.rec.instr_len     = cur_len;
        push.rec.operand       = (cur_len == 2'd3) ? {data_byte, operand_low}
                                                    : {8'd0, data_byte};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      halted     <= 1'b1;
      bytes_left <= 2'd0;
    end else begin
      halted     <= halted_next;
      bytes_left <= bytes_left_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_addr    <= cur_addr_next;
    cur_opcode  <= cur_opcode_next;
    cur_mn      <= cur_mn_next;
    cur_mode    <= cur_mode_next;
    operand_low <= operand_low_next;
  end

  // records come only from accepted bytes
  a_push_on_fire: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> fire)
    else $error("record without transfer");

  // a halted walker with no restart stays silent
  a_halted_quiet: assert property (@(posedge clk) disable iff (rst)
    (halted && !restart) |-> !push.valid)
    else $error("record while halted");

  // operand count never reaches three
  a_bytes_left: assert property (@(posedge clk) disable iff (rst)
    bytes_left != 2'd3)
    else $error("bad operand count");

endmodule

[sv/isld_out_buf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isld_out_buf
// Two-entry result buffer; keeps input ready a registered function of fill.
// ----------------------------------------------------------------------------
module isld_out_buf import isld_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  isld_push_t push,
  output logic       can_take,
  output logic       out_valid,
  input  logic       out_ready,
  output isld_rec_t  out_rec
);

  isld_rec_t  entry [2];
  logic       head, head_next;
  logic       tail, tail_next;
  logic [1:0] count, count_next;
  logic       pop;

  assign can_take  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_rec   = entry[head];
  assign pop       = out_valid & out_ready;

  always_comb begin
    head_next  = head ^ pop;
    tail_next  = tail ^ push.valid;
    count_next = count + {1'b0, push.valid} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 1'b0;
      tail  <= 1'b0;
      count <= 2'd0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entry[tail] <= push.rec;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> can_take)
    else $error("push into full buffer");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("fill count out of range");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && !push.valid) |=> (count == $past(count) - 2'd1))
    else $error("pop did not drain");

endmodule

[sv/instr_stream_length_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// instr_stream_length_decoder
// Walks a program byte stream, decodes opcodes and emits instruction records.
// ----------------------------------------------------------------------------
// A record is written to the result buffer when the byte that completes it is taken.
// Throughput: one byte per cycle while the buffer is not full; the two-entry
//   result buffer decouples input ready from output ready.
// Reset: walker halted waiting for restart, buffer empty, memory_top 0xFFFF.
// ----------------------------------------------------------------------------
module instr_stream_length_decoder import isld_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // data_byte[7:0], byte_addr[23:8]
  input  logic        s_tuser,   // restart
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // instr_addr, opcode, mnemonic_code,
                                 // addr_mode, operand, instr_len, zero pad
  output logic [1:0]  m_tuser,   // status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data   // memory_top
);

  logic [15:0] memory_top;
  isld_push_t  push;
  isld_rec_t   rec;
  logic        fire;

  assign cfg_ready = 1'b1;
  assign fire      = s_tvalid & s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      memory_top <= 16'hFFFF;
    end else if (cfg_valid) begin
      memory_top <= cfg_data;
    end
  end

  isld_walker u_walker (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .data_byte  (s_tdata[7:0]),
    .byte_addr  (s_tdata[23:8]),
    .restart    (s_tuser),
    .memory_top (memory_top),
    .push       (push)
  );

  isld_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .can_take  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_rec   (rec)
  );

  assign m_tdata = {4'd0, rec.instr_len, rec.operand, rec.addr_mode,
                    rec.mnemonic_code, rec.opcode, rec.instr_addr};
  assign m_tuser = rec.status;

endmodule
